FILE: sv/smmu_pkg.sv
// ----------------------------------------------------------------------------
// smmu_pkg
// Shared constants, codes and types of the segmented memory map unit.
// ----------------------------------------------------------------------------
package smmu_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_WORDS    = 1024;

  // item field widths
  localparam int OP_W   = 2;
  localparam int SEG_W  = 8;
  localparam int OFF_W  = 10;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 3;

  localparam int ID_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W = $clog2(MAX_SEGMENTS * SEG_WORDS);

  typedef enum logic [OP_W-1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_LOAD  = 2'd2,
    OP_STORE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_ID    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_UNMAPPED = 3'd3,
    ST_OFFSET   = 3'd4,
    ST_SEG_ZERO = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic            alloc;
    logic            release_id;
    logic [ID_W-1:0] id;
  } alloc_req_t;

  typedef struct packed {
    logic            has_id;
    logic [ID_W-1:0] id;
  } alloc_rsp_t;

  function automatic logic [ADDR_W-1:0] word_addr(logic [SEG_W-1:0] seg,
                                                  logic [OFF_W-1:0] off);
    return ADDR_W'(int'(seg) * SEG_WORDS + int'(off));
  endfunction

endpackage

FILE: sv/smmu_if.sv
// ----------------------------------------------------------------------------
// smmu_in_if / smmu_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface smmu_in_if;
  logic                        valid;
  logic                        ready;
  logic [smmu_pkg::OP_W-1:0]   operation;
  logic [smmu_pkg::SEG_W-1:0]  segment;
  logic [smmu_pkg::OFF_W-1:0]  offset;
  logic [smmu_pkg::WORD_W-1:0] write_value;
  logic [smmu_pkg::LEN_W-1:0]  map_length;

  modport source (output valid, operation, segment, offset, write_value, map_length,
                  input ready);
  modport sink (input valid, operation, segment, offset, write_value, map_length,
                output ready);
endinterface

interface smmu_out_if;
  logic                        valid;
  logic                        ready;
  logic [smmu_pkg::SEG_W-1:0]  segment_id;
  logic [smmu_pkg::WORD_W-1:0] read_value;
  logic [smmu_pkg::STAT_W-1:0] status;

  modport source (output valid, segment_id, read_value, status, input ready);
  modport sink (input valid, segment_id, read_value, status, output ready);
endinterface

FILE: sv/smmu_ram.sv
// ----------------------------------------------------------------------------
// smmu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smmu_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/smmu_id_alloc.sv
// ----------------------------------------------------------------------------
// smmu_id_alloc
// Segment id allocator: FIFO of freed ids in RAM, then never-used ids.
// ----------------------------------------------------------------------------
module smmu_id_alloc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smmu_pkg::alloc_req_t req,
  output smmu_pkg::alloc_rsp_t rsp
);

  logic [smmu_pkg::ID_W-1:0]  head_r, head_nxt;
  logic [smmu_pkg::ID_W-1:0]  tail_r, tail_nxt;
  logic [smmu_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [smmu_pkg::CNT_W-1:0] next_new_r, next_new_nxt;
  logic [smmu_pkg::ID_W-1:0]  q_rdata;
  logic                       q_we;
  logic                       q_nonempty;
  logic                       new_avail;

  localparam logic [smmu_pkg::ID_W-1:0] LAST_IDX = smmu_pkg::ID_W'(smmu_pkg::MAX_SEGMENTS - 1);

  // head entry is read every cycle; data is valid the cycle after
  smmu_ram #(
    .DEPTH (smmu_pkg::MAX_SEGMENTS),
    .WIDTH (smmu_pkg::ID_W)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (req.id),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  assign q_nonempty = (count_r != '0);
  assign new_avail  = (next_new_r < smmu_pkg::CNT_W'(smmu_pkg::MAX_SEGMENTS));
  assign rsp.has_id = q_nonempty || new_avail;
  assign rsp.id     = q_nonempty ? q_rdata : smmu_pkg::ID_W'(next_new_r);
  assign q_we       = req.release_id && (count_r < smmu_pkg::CNT_W'(smmu_pkg::MAX_SEGMENTS));

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    next_new_nxt = next_new_r;
    if (req.alloc) begin
      if (q_nonempty) begin
        head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
        count_nxt = count_r - 1'b1;
      end else begin
        next_new_nxt = next_new_r + 1'b1;
      end
    end else if (q_we) begin
      tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      next_new_r <= '0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      next_new_r <= next_new_nxt;
    end
  end

endmodule

FILE: sv/segmented_memory_map_unit.sv
// ----------------------------------------------------------------------------
// segmented_memory_map_unit
// Segmented word memory: map, unmap, load and store of segment words.
//
//   channel  dir  beat
//   in_ch    in   operation, segment, offset, write_value, map_length
//   out_ch   out  segment_id, read_value, status (one per operation)
//
// Unmap, load and store: accept and memory read in S_IDLE, then execute in S_EXEC.
// Map also zeroes the new segment's first map_length words after S_EXEC, one
// per cycle in S_CLEAR through the word memory write port.
// Reset clears the mapped bits and allocator at once; no clearing pass.
// A result waits in the output register; the next beat is taken as it leaves.
// ----------------------------------------------------------------------------
module segmented_memory_map_unit (
  input  logic              clk,
  input  logic              rst_n,
  smmu_in_if.sink           in_ch,
  smmu_out_if.source        out_ch
);

  smmu_pkg::state_t state_r, state_nxt;

  logic [smmu_pkg::MAX_SEGMENTS-1:0] mapped_r, mapped_nxt;

  smmu_pkg::op_t               item_op_r, item_op_nxt;
  logic [smmu_pkg::SEG_W-1:0]  item_seg_r, item_seg_nxt;
  logic [smmu_pkg::OFF_W-1:0]  item_off_r, item_off_nxt;
  logic [smmu_pkg::WORD_W-1:0] item_val_r, item_val_nxt;
  logic [smmu_pkg::LEN_W-1:0]  item_len_r, item_len_nxt;

  logic [smmu_pkg::ADDR_W-1:0] clr_base_r, clr_base_nxt;
  logic [smmu_pkg::LEN_W-1:0]  clr_len_r, clr_len_nxt;
  logic [smmu_pkg::LEN_W-1:0]  clr_cnt_r, clr_cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [smmu_pkg::SEG_W-1:0]  out_id_r, out_id_nxt;
  logic [smmu_pkg::WORD_W-1:0] out_rd_r, out_rd_nxt;
  smmu_pkg::status_t           out_st_r, out_st_nxt;

  logic                        word_we;
  logic [smmu_pkg::ADDR_W-1:0] word_waddr;
  logic [smmu_pkg::WORD_W-1:0] word_wdata;
  logic [smmu_pkg::WORD_W-1:0] word_rdata;
  logic                        len_we;
  logic [smmu_pkg::ID_W-1:0]   len_waddr;
  logic [smmu_pkg::LEN_W-1:0]  len_rdata;

  smmu_pkg::alloc_req_t areq;
  smmu_pkg::alloc_rsp_t arsp;

  logic                      in_fire;
  logic [smmu_pkg::ID_W-1:0] seg_idx;
  logic                      seg_ok;

  assign in_ch.ready  = (state_r == smmu_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.segment_id = out_id_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.status     = out_st_r;

  assign seg_idx = smmu_pkg::ID_W'(item_seg_r);
  assign seg_ok  = (int'(item_seg_r) < smmu_pkg::MAX_SEGMENTS) && mapped_r[seg_idx];

  smmu_ram #(
    .DEPTH (smmu_pkg::MAX_SEGMENTS * smmu_pkg::SEG_WORDS),
    .WIDTH (smmu_pkg::WORD_W)
  ) u_words (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .raddr (smmu_pkg::word_addr(in_ch.segment, in_ch.offset)),
    .rdata (word_rdata)
  );

  smmu_ram #(
    .DEPTH (smmu_pkg::MAX_SEGMENTS),
    .WIDTH (smmu_pkg::LEN_W)
  ) u_lengths (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (item_len_r),
    .raddr (smmu_pkg::ID_W'(in_ch.segment)),
    .rdata (len_rdata)
  );

  smmu_id_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  always_comb begin
    state_nxt     = state_r;
    mapped_nxt    = mapped_r;
    item_op_nxt   = item_op_r;
    item_seg_nxt  = item_seg_r;
    item_off_nxt  = item_off_r;
    item_val_nxt  = item_val_r;
    item_len_nxt  = item_len_r;
    clr_base_nxt  = clr_base_r;
    clr_len_nxt   = clr_len_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_id_nxt    = out_id_r;
    out_rd_nxt    = out_rd_r;
    out_st_nxt    = out_st_r;
    word_we       = 1'b0;
    word_waddr    = smmu_pkg::word_addr(item_seg_r, item_off_r);
    word_wdata    = item_val_r;
    len_we        = 1'b0;
    len_waddr     = arsp.id;
    areq          = '0;
    areq.id       = seg_idx;

    case (state_r)
      smmu_pkg::S_IDLE: begin
        if (in_fire) begin
          item_op_nxt  = smmu_pkg::op_t'(in_ch.operation);
          item_seg_nxt = in_ch.segment;
          item_off_nxt = in_ch.offset;
          item_val_nxt = in_ch.write_value;
          item_len_nxt = in_ch.map_length;
          state_nxt    = smmu_pkg::S_EXEC;
        end
      end
      smmu_pkg::S_EXEC: begin
        state_nxt     = smmu_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        out_rd_nxt    = '0;
        out_st_nxt    = smmu_pkg::ST_OK;
        case (item_op_r)
          smmu_pkg::OP_MAP: begin
            if (item_len_r > smmu_pkg::LEN_W'(smmu_pkg::SEG_WORDS)) begin
              out_st_nxt = smmu_pkg::ST_TOO_LONG;
            end else if (!arsp.has_id) begin
              out_st_nxt = smmu_pkg::ST_NO_ID;
            end else begin
              areq.alloc           = 1'b1;
              out_id_nxt           = smmu_pkg::SEG_W'(arsp.id);
              len_we               = 1'b1;
              mapped_nxt[arsp.id]  = 1'b1;
              if (item_len_r != '0) begin
                clr_base_nxt = smmu_pkg::ADDR_W'(int'(arsp.id) * smmu_pkg::SEG_WORDS);
                clr_len_nxt  = item_len_r;
                clr_cnt_nxt  = '0;
                state_nxt    = smmu_pkg::S_CLEAR;
              end
            end
          end
          smmu_pkg::OP_UNMAP: begin
            if (item_seg_r == '0) begin
              out_st_nxt = smmu_pkg::ST_SEG_ZERO;
            end else if (!seg_ok) begin
              out_st_nxt = smmu_pkg::ST_UNMAPPED;
            end else begin
              mapped_nxt[seg_idx] = 1'b0;
              areq.release_id     = 1'b1;
            end
          end
          smmu_pkg::OP_LOAD, smmu_pkg::OP_STORE: begin
            if (!seg_ok) begin
              out_st_nxt = smmu_pkg::ST_UNMAPPED;
            end else if (smmu_pkg::LEN_W'(item_off_r) >= len_rdata) begin
              out_st_nxt = smmu_pkg::ST_OFFSET;
            end else if (item_op_r == smmu_pkg::OP_LOAD) begin
              out_rd_nxt = word_rdata;
            end else begin
              word_we = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      smmu_pkg::S_CLEAR: begin
        word_we     = 1'b1;
        word_waddr  = clr_base_r + smmu_pkg::ADDR_W'(clr_cnt_r);
        word_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_nxt == clr_len_r) begin
          state_nxt = smmu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = smmu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smmu_pkg::S_IDLE;
      mapped_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mapped_r    <= mapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_op_r  <= item_op_nxt;
    item_seg_r <= item_seg_nxt;
    item_off_r <= item_off_nxt;
    item_val_r <= item_val_nxt;
    item_len_r <= item_len_nxt;
    clr_base_r <= clr_base_nxt;
    clr_len_r  <= clr_len_nxt;
    clr_cnt_r  <= clr_cnt_nxt;
    out_id_r   <= out_id_nxt;
    out_rd_r   <= out_rd_nxt;
    out_st_r   <= out_st_nxt;
  end

  // accepted beat is executed in S_EXEC and its result then held in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##2 out_ch.valid)
    else $error("result missing after accepted beat");

  // no beat accepted while a segment is being zeroed
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smmu_pkg::S_CLEAR) |-> (!in_ch.ready && word_we && (word_wdata == '0)))
    else $error("beat accepted or word not zeroed during clear");

  // failed operations return zero id and zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != smmu_pkg::ST_OK)) |->
      ((out_ch.segment_id == '0) && (out_ch.read_value == '0)))
    else $error("nonzero fields on failed operation");

  // a store never writes outside the execute step
  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    (word_we && (state_r != smmu_pkg::S_CLEAR)) |->
      ((state_r == smmu_pkg::S_EXEC) && (item_op_r == smmu_pkg::OP_STORE) && seg_ok))
    else $error("word write outside store or clear");

endmodule
